// ===== rtl/core/stq_pkg.sv =====
// package: shared types and constants for the 2d sparse table block
package stq_pkg;

   localparam int ModeWidth   = 2;
   localparam int StatusWidth = 2;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 5;

   localparam logic [ModeWidth-1:0] MODE_WRITE = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_BUILD = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_QUERY = 2'd2;

   localparam logic [StatusWidth-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_NOT_BUILT = 2'd2;

   localparam logic [CsrAddrWidth-1:0] CSR_OP_SELECT = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_GRID_COLS = 2'd2;

   // input item fields
   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic [3:0]           row_first;
      logic [3:0]           col_first;
      logic [3:0]           row_last;
      logic [3:0]           col_last;
      logic signed [15:0]   cell_value;
   } req_item_type;

   // result item fields
   typedef struct packed {
      logic [ModeWidth-1:0]   kind;
      logic signed [15:0]     answer;
      logic [StatusWidth-1:0] status;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD_RD0,
      ST_BUILD_RD1,
      ST_BUILD_WR,
      ST_QUERY_RD,
      ST_QUERY_CMB,
      ST_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_item;    // capture input item, check range
      logic write_cell;   // store the captured cell
      logic build_start;  // reset build indices
      logic build_rd0;    // read first operand
      logic build_rd1;    // read second operand
      logic build_wr;     // combine and write, advance
      logic query_rd;     // issue next query read
      logic query_cmb;    // final read is folded in this state
      logic set_built;
      logic clear_built;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic build_skip;   // current build slot is outside the grid or on a base level
      logic build_last;   // current build slot is the final one
      logic query_last;   // fourth query read issued
      logic query_ok;     // range good and table built
      logic write_ok;     // write inside the grid
   } stat_type;

endpackage

// ===== rtl/core/stq_if.sv =====
// interface: valid/ready channel carrying one payload item
interface stq_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/stq_ctrl.sv =====
// controller: sequences writes, builds and queries
module stq_ctrl
   import stq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [ModeWidth-1:0] req_mode,
   input  logic                 rsp_free,
   output logic                 req_ready,
   output logic                 rsp_load,
   output cmd_type              cmd,
   input  stat_type             stat
);

   state_type state_ff, state_in;
   logic [ModeWidth-1:0] mode_ff, mode_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_WRITE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               mode_in = req_mode;
               case (req_mode)
                  MODE_BUILD: state_in = ST_BUILD_RD0;
                  MODE_QUERY: state_in = ST_QUERY_RD;
                  default:    state_in = ST_RESP;
               endcase
               if (req_mode == MODE_BUILD) cmd.build_start = 1'b1;
            end
         end
         ST_BUILD_RD0: begin
            if (stat.build_skip) begin
               cmd.build_wr = 1'b1;
               if (stat.build_last) state_in = ST_RESP;
            end else begin
               cmd.build_rd0 = 1'b1;
               state_in = ST_BUILD_RD1;
            end
         end
         ST_BUILD_RD1: begin
            cmd.build_rd1 = 1'b1;
            state_in = ST_BUILD_WR;
         end
         ST_BUILD_WR: begin
            cmd.build_wr = 1'b1;
            state_in = stat.build_last ? ST_RESP : ST_BUILD_RD0;
         end
         ST_QUERY_RD: begin
            if (!stat.query_ok) begin
               state_in = ST_RESP;
            end else begin
               cmd.query_rd = 1'b1;
               if (stat.query_last) state_in = ST_QUERY_CMB;
            end
         end
         ST_QUERY_CMB: begin
            cmd.query_cmb = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (mode_ff == MODE_BUILD) cmd.set_built = 1'b1;
               if (mode_ff == MODE_WRITE && stat.write_ok) begin
                  cmd.write_cell  = 1'b1;
                  cmd.clear_built = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a response is loaded only from the response state
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> state_ff == ST_RESP)
      else $error("response loaded outside response state");
   // after taking an item the controller leaves idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff != ST_IDLE)
      else $error("controller stayed idle after taking an item");
   // setting and clearing the built mark are exclusive
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.set_built && cmd.clear_built))
      else $error("built mark set and cleared together");

endmodule

// ===== rtl/core/stq_datapath.sv =====
// datapath: table memory, build indices, query address and combine
module stq_datapath
   import stq_pkg::*;
#(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLS    = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output stat_type                     stat,
   input  logic [ModeWidth-1:0]         in_mode,
   input  logic [3:0]                   in_row_first,
   input  logic [3:0]                   in_col_first,
   input  logic [3:0]                   in_row_last,
   input  logic [3:0]                   in_col_last,
   input  logic signed [VALUE_WIDTH-1:0] in_value,
   input  logic                         csr_write_enable,
   input  logic [CsrAddrWidth-1:0]      csr_index,
   input  logic [CsrDataWidth-1:0]      csr_write_data,
   output logic [ModeWidth-1:0]         out_kind,
   output logic [StatusWidth-1:0]       out_status,
   output logic signed [VALUE_WIDTH-1:0] out_answer
);

   localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RowLevels = $clog2(MAX_ROWS) + 1;
   localparam int ColLevels = $clog2(MAX_COLS) + 1;
   localparam int KB = (RowLevels > 1) ? $clog2(RowLevels) : 1;
   localparam int LB = (ColLevels > 1) ? $clog2(ColLevels) : 1;
   localparam int Depth = RowLevels * ColLevels * MAX_ROWS * MAX_COLS;
   localparam int AB = $clog2(Depth);
   localparam int CW = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 2;
   localparam logic [CW-1:0] RowsMax = CW'(MAX_ROWS);
   localparam logic [CW-1:0] ColsMax = CW'(MAX_COLS);

   // configuration registers
   logic          op_ff;
   logic [CW-1:0] rows_ff, cols_ff;
   logic          built_ff;
   logic [CW-1:0] csr_sat;

   always_comb begin
      csr_sat = CW'(csr_write_data);
      if (csr_index == CSR_GRID_ROWS) begin
         if (csr_sat == '0) csr_sat = CW'(1);
         else if (csr_sat > RowsMax) csr_sat = RowsMax;
      end else begin
         if (csr_sat == '0) csr_sat = CW'(1);
         else if (csr_sat > ColsMax) csr_sat = ColsMax;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= 1'b0;
         rows_ff  <= (RowsMax > CW'(16)) ? CW'(16) : RowsMax;
         cols_ff  <= (ColsMax > CW'(16)) ? CW'(16) : ColsMax;
         built_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_OP_SELECT: op_ff <= csr_write_data[0];
               CSR_GRID_ROWS: rows_ff <= csr_sat;
               CSR_GRID_COLS: cols_ff <= csr_sat;
               default: ;
            endcase
            if (csr_index == CSR_OP_SELECT || csr_index == CSR_GRID_ROWS ||
                csr_index == CSR_GRID_COLS) built_ff <= 1'b0;
         end else if (cmd.set_built) begin
            built_ff <= 1'b1;
         end else if (cmd.clear_built) begin
            built_ff <= 1'b0;
         end
      end
   end

   // combine: signed min or max
   function automatic logic signed [VALUE_WIDTH-1:0] combine(
      input logic op, input logic signed [VALUE_WIDTH-1:0] a,
      input logic signed [VALUE_WIDTH-1:0] b);
      logic a_less;
      a_less = a < b;
      return (op ^ a_less) ? a : b;
   endfunction

   function automatic logic [AB-1:0] slot(input logic [KB-1:0] k,
      input logic [LB-1:0] l, input logic [CW-1:0] i, input logic [CW-1:0] j);
      return AB'(((k * ColLevels + l) * MAX_ROWS + i) * MAX_COLS + j);
   endfunction

   function automatic logic [KB-1:0] flog2(input logic [CW-1:0] n);
      logic [KB-1:0] r;
      r = '0;
      for (int b = 1; b < CW; b++) if (n[b]) r = KB'(b);
      return r;
   endfunction

   // captured item
   logic [ModeWidth-1:0] mode_ff;
   logic [CW-1:0] r1_ff, c1_ff, r2_ff, c2_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic range_ok_ff, write_ok_ff;
   logic range_ok_in, write_ok_in;
   logic [CW-1:0] r1_w, c1_w, r2_w, c2_w;

   assign r1_w = CW'(in_row_first);
   assign c1_w = CW'(in_col_first);
   assign r2_w = CW'(in_row_last);
   assign c2_w = CW'(in_col_last);
   assign range_ok_in = !(r1_w > r2_w || r2_w >= rows_ff || c1_w > c2_w || c2_w >= cols_ff);
   assign write_ok_in = (r1_w < rows_ff) && (c1_w < cols_ff);

   // query geometry, registered at capture
   logic [KB-1:0] qk_ff;
   logic [LB-1:0] ql_ff;
   logic [CW-1:0] rb_ff, cr_ff;
   logic [KB-1:0] qk_in;
   logic [LB-1:0] ql_in;
   logic [CW-1:0] rh, cw_;

   always_comb begin
      qk_in = flog2(r2_w - r1_w + CW'(1));
      ql_in = LB'(flog2(c2_w - c1_w + CW'(1)));
      rh  = CW'(1) << qk_in;
      cw_ = CW'(1) << ql_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff     <= in_mode;
         r1_ff       <= r1_w;
         c1_ff       <= c1_w;
         r2_ff       <= r2_w;
         c2_ff       <= c2_w;
         value_ff    <= in_value;
         range_ok_ff <= range_ok_in;
         write_ok_ff <= write_ok_in;
         qk_ff       <= qk_in;
         ql_ff       <= ql_in;
         rb_ff       <= r2_w + CW'(1) - rh;
         cr_ff       <= c2_w + CW'(1) - cw_;
      end
   end

   // build walk: phase 0 along columns at row level 0, phase 1 row levels
   logic          phase_ff;
   logic [KB-1:0] bk_ff;
   logic [LB-1:0] bl_ff;
   logic [CW-1:0] bi_ff, bj_ff;
   logic [KB-1:0] kn;
   logic [LB-1:0] ln;
   logic [CW-1:0] bh, bw;
   logic          skip, last_j, last_i, last_l, last_k, last_all;

   always_comb begin
      kn = flog2(rows_ff);
      ln = LB'(flog2(cols_ff));
      bh = phase_ff ? (CW'(1) << bk_ff) : CW'(1);
      bw = CW'(1) << bl_ff;
      skip = (bi_ff + bh > rows_ff) || (bj_ff + bw > cols_ff) ||
             (!phase_ff && bl_ff == '0) || (phase_ff && bk_ff == '0);
      last_j = bj_ff == CW'(MAX_COLS - 1);
      last_i = bi_ff == CW'(MAX_ROWS - 1);
      last_l = bl_ff >= ln;
      last_k = bk_ff >= kn;
      last_all = last_j && last_i && last_l && (phase_ff ? last_k : (kn == '0));
   end

   assign stat.build_skip = skip;
   assign stat.build_last = last_all;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         bk_ff <= '0;
         bl_ff <= '0;
         bi_ff <= '0;
         bj_ff <= '0;
      end else if (cmd.build_start) begin
         phase_ff <= 1'b0;
         bk_ff <= '0;
         bl_ff <= '0;
         bi_ff <= '0;
         bj_ff <= '0;
      end else if (cmd.build_wr) begin
         if (!last_j) begin
            bj_ff <= bj_ff + CW'(1);
         end else begin
            bj_ff <= '0;
            if (!last_i) begin
               bi_ff <= bi_ff + CW'(1);
            end else begin
               bi_ff <= '0;
               if (!last_l) begin
                  bl_ff <= bl_ff + LB'(1);
               end else begin
                  bl_ff <= '0;
                  if (!phase_ff) begin
                     phase_ff <= 1'b1;
                     bk_ff <= KB'(1);
                  end else begin
                     bk_ff <= bk_ff + KB'(1);
                  end
               end
            end
         end
      end
   end

   // query read sequencer
   logic [1:0] qn_ff;
   logic       query_ok;
   assign query_ok = range_ok_ff && built_ff;
   assign stat.query_ok = query_ok;
   assign stat.query_last = qn_ff == 2'd3;
   assign stat.write_ok = write_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) qn_ff <= '0;
      else if (cmd.load_item) qn_ff <= '0;
      else if (cmd.query_rd) qn_ff <= qn_ff + 2'd1;
   end

   // memory address select
   logic [AB-1:0] rd_addr, wr_addr;
   logic [KB-1:0] half_k;
   logic [LB-1:0] half_l;
   logic [CW-1:0] qi, qj;

   always_comb begin
      half_k = bk_ff - KB'(1);
      half_l = bl_ff - LB'(1);
      qi = qn_ff[1] ? rb_ff : r1_ff;
      qj = qn_ff[0] ? cr_ff : c1_ff;
      if (cmd.query_rd) rd_addr = slot(qk_ff, ql_ff, qi, qj);
      else if (!phase_ff) begin
         rd_addr = cmd.build_rd1
            ? slot('0, half_l, bi_ff, bj_ff + (CW'(1) << half_l))
            : slot('0, half_l, bi_ff, bj_ff);
      end else begin
         rd_addr = cmd.build_rd1
            ? slot(half_k, bl_ff, bi_ff + (CW'(1) << half_k), bj_ff)
            : slot(half_k, bl_ff, bi_ff, bj_ff);
      end
      wr_addr = cmd.write_cell ? slot('0, '0, r1_ff, c1_ff)
                               : slot(phase_ff ? bk_ff : '0, bl_ff, bi_ff, bj_ff);
   end

   // table memory
   logic signed [VALUE_WIDTH-1:0] mem [Depth];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic signed [VALUE_WIDTH-1:0] opnd_ff, acc_ff;
   logic rd_valid_ff;
   logic mem_we;
   logic signed [VALUE_WIDTH-1:0] wr_data;

   assign mem_we = cmd.write_cell || (cmd.build_wr && !skip);
   assign wr_data = cmd.write_cell ? value_ff : combine(op_ff, opnd_ff, rd_data_ff);

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // operand hold and query accumulator: first read loads, the next three fold
   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else rd_valid_ff <= cmd.query_rd && qn_ff != 2'd0;
      if (cmd.build_rd1) opnd_ff <= rd_data_ff;
      if (cmd.query_rd && qn_ff == 2'd1) acc_ff <= rd_data_ff;
      else if (rd_valid_ff) acc_ff <= combine(op_ff, acc_ff, rd_data_ff);
   end

   assign out_kind = mode_ff;

   // response fields
   always_comb begin
      out_answer = '0;
      out_status = STATUS_OK;
      case (mode_ff)
         MODE_WRITE: out_status = write_ok_ff ? STATUS_OK : STATUS_RANGE;
         MODE_BUILD: out_status = STATUS_OK;
         MODE_QUERY: begin
            if (!range_ok_ff) out_status = STATUS_RANGE;
            else if (!built_ff) out_status = STATUS_NOT_BUILT;
            else out_answer = acc_ff;
         end
         default: out_status = STATUS_RANGE;
      endcase
   end

   // query reads never run on a bad range
   assert property (@(posedge clock) disable iff (reset)
      cmd.query_rd |-> range_ok_ff && built_ff)
      else $error("query read without valid range");
   // memory writes never collide with query reads
   assert property (@(posedge clock) disable iff (reset)
      !(mem_we && cmd.query_rd))
      else $error("table write during query");
   // the built mark rises only by a build
   assert property (@(posedge clock) disable iff (reset)
      $rose(built_ff) |-> $past(cmd.set_built))
      else $error("built mark set without build");

endmodule

// ===== rtl/core/sparse_table_2d_range_query_top.sv =====
// top level: 2d sparse table range min/max query block
//
//  channel | dir | handshake         | payload
//  req     | in  | req.valid/ready   | mode, row/col first/last, cell_value
//  rsp     | out | rsp.valid/ready   | kind, answer, status
//  csr     | in  | csr_write_enable  | csr_index, csr_write_data
//
// write: capture, then response; query: four reads from the one
// table memory port plus combine; build: walks every table slot over
// all row and column levels, limited by the single memory read port.
// reset clears control and config; table contents are undefined until written.
// an item is taken once the previous result has moved into the output register.
module sparse_table_2d_range_query_top
   import stq_pkg::*;
#(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLS    = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   stq_if.sink                     req,
   stq_if.source                   rsp,
   input  logic                    csr_write_enable,
   input  logic [CsrAddrWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_load;
   logic     rsp_valid_ff;
   logic [ModeWidth-1:0] kind_ff, dp_kind;
   logic [StatusWidth-1:0] status_ff, dp_status;
   logic signed [VALUE_WIDTH-1:0] answer_ff, dp_answer;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.payload.mode),
      .rsp_free  (!rsp_valid_ff || rsp.ready),
      .req_ready (req.ready),
      .rsp_load  (rsp_load),
      .cmd       (cmd),
      .stat      (stat)
   );

   stq_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_mode          (req.payload.mode),
      .in_row_first     (req.payload.row_first),
      .in_col_first     (req.payload.col_first),
      .in_row_last      (req.payload.row_last),
      .in_col_last      (req.payload.col_last),
      .in_value         (VALUE_WIDTH'(req.payload.cell_value)),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .out_kind         (dp_kind),
      .out_status       (dp_status),
      .out_answer       (dp_answer)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
      if (rsp_load) begin
         kind_ff   <= dp_kind;
         status_ff <= dp_status;
         answer_ff <= dp_answer;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.payload.kind   = kind_ff;
   assign rsp.payload.status = status_ff;
   assign rsp.payload.answer = 16'(answer_ff);

   // a result is not overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !rsp_load)
      else $error("pending result overwritten");
   // held result keeps its fields
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.payload))
      else $error("result changed while stalled");
   // items are not taken while a build or query runs
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("second item taken back to back");

endmodule

// ===== sim/tb.sv =====
// testbench for the 2d sparse table range min/max query block
module tb;
   import stq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ModeWidth-1:0] MODE_UNUSED = 2'd3;
   localparam int NumPhases = 8;
   localparam int ItemsPerPhase = 220;
   localparam int ItemBits = $bits(req_item_type);

   // predictor of the block plus the store of expected results
   class range_table_sb;
      logic signed [15:0] blk[5][5][16][16];
      bit      built;
      bit      use_max;
      int      rows;
      int      cols;
      rsp_item_type pending[$];
      int      mismatches;
      int      matched;

      function new();
         built = 0;
         use_max = 0;
         rows = 16;
         cols = 16;
         mismatches = 0;
         matched = 0;
         foreach (blk[a, b, c, d]) blk[a][b][c][d] = '0;
      endfunction

      function logic signed [15:0] pick(logic signed [15:0] a, logic signed [15:0] b);
         if (use_max) return (a < b) ? b : a;
         return (a < b) ? a : b;
      endfunction

      function int lg2(int n);
         int r;
         r = 0;
         while (n > 1) begin
            n = n >> 1;
            r++;
         end
         return r;
      endfunction

      function void set_reg(logic [CsrAddrWidth-1:0] idx, logic [CsrDataWidth-1:0] v);
         int n;
         n = int'(v);
         case (idx)
            CSR_OP_SELECT: use_max = v[0];
            CSR_GRID_ROWS: rows = (n < 1) ? 1 : ((n > 16) ? 16 : n);
            CSR_GRID_COLS: cols = (n < 1) ? 1 : ((n > 16) ? 16 : n);
            default: return;
         endcase
         built = 0;
      endfunction

      // column levels first, then row levels on top of them
      function void rebuild();
         int kn, ln, w, h;
         kn = lg2(rows) + 1;
         ln = lg2(cols) + 1;
         for (int l = 1; l < ln; l++) begin
            w = 1 << l;
            for (int i = 0; i < rows; i++)
               for (int j = 0; j + w <= cols; j++)
                  blk[0][l][i][j] = pick(blk[0][l-1][i][j], blk[0][l-1][i][j + w/2]);
         end
         for (int k = 1; k < kn; k++) begin
            h = 1 << k;
            for (int l = 0; l < ln; l++) begin
               w = 1 << l;
               for (int i = 0; i + h <= rows; i++)
                  for (int j = 0; j + w <= cols; j++)
                     blk[k][l][i][j] = pick(blk[k-1][l][i][j], blk[k-1][l][i + h/2][j]);
            end
         end
         built = 1;
      endfunction

      function void note_item(req_item_type it);
         rsp_item_type e;
         int r1, c1, r2, c2, k, l, rb, cr;
         logic signed [15:0] top, bot;
         r1 = it.row_first;
         c1 = it.col_first;
         r2 = it.row_last;
         c2 = it.col_last;
         e.kind = it.mode;
         e.answer = '0;
         e.status = STATUS_OK;
         case (it.mode)
            MODE_WRITE: begin
               if (r1 >= rows || c1 >= cols) e.status = STATUS_RANGE;
               else begin
                  blk[0][0][r1][c1] = it.cell_value;
                  built = 0;
               end
            end
            MODE_BUILD: rebuild();
            MODE_QUERY: begin
               if (r1 > r2 || r2 >= rows || c1 > c2 || c2 >= cols) e.status = STATUS_RANGE;
               else if (!built) e.status = STATUS_NOT_BUILT;
               else begin
                  k = lg2(r2 - r1 + 1);
                  l = lg2(c2 - c1 + 1);
                  rb = r2 + 1 - (1 << k);
                  cr = c2 + 1 - (1 << l);
                  top = pick(blk[k][l][r1][c1], blk[k][l][r1][cr]);
                  bot = pick(blk[k][l][rb][c1], blk[k][l][rb][cr]);
                  e.answer = pick(top, bot);
               end
            end
            default: e.status = STATUS_RANGE;
         endcase
         pending.push_back(e);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result kind=%0d answer=%0d status=%0d",
                        got.kind, got.answer, got.status);
            return;
         end
         e = pending.pop_front();
         if (got.kind !== e.kind || got.answer !== e.answer || got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected kind=%0d answer=%0d status=%0d, got %0d %0d %0d",
                        e.kind, e.answer, e.status, got.kind, got.answer, got.status);
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrAddrWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   stq_if #(.payload_type(req_item_type)) req_ch ();
   stq_if #(.payload_type(rsp_item_type)) rsp_ch ();

   sparse_table_2d_range_query_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   range_table_sb sb = new();
   bit written[16][16];
   bit calm;
   int results_seen;
   int builds_sent;
   int queries_sent;

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // gap length: mostly short, a few long
   function int gap_len();
      int r;
      r = $urandom_range(99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // result side: random ready, one long hold-off, check each accepted item
   initial begin
      bit           fire;
      rsp_item_type got;
      int           hold;
      bit           held;
      rsp_ch.ready = 1'b0;
      results_seen = 0;
      held = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         fire = rsp_ch.valid && rsp_ch.ready;
         got = rsp_ch.payload;
         @(posedge clock);
         if (fire) begin
            sb.check_result(got);
            results_seen++;
         end
         if (!held && results_seen == 150) begin
            held = 1;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (gap_len() == 0);
         end
      end
   end

   task automatic send_item(req_item_type it);
      int  gap;
      bit  rdy;
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= it;
      do begin
         @(negedge clock);
         rdy = req_ch.ready;
         @(posedge clock);
      end while (!rdy);
      if (it.mode == MODE_WRITE && it.row_first < sb.rows && it.col_first < sb.cols)
         written[it.row_first][it.col_first] = 1;
      if (it.mode == MODE_BUILD) builds_sent++;
      if (it.mode == MODE_QUERY) queries_sent++;
      sb.note_item(it);
   endtask

   // one register write, then the enable goes low before the next
   task automatic csr_write(logic [CsrAddrWidth-1:0] idx, logic [CsrDataWidth-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   // wait for every expected result, then let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_item_type make_item(logic [1:0] m, int r1, int c1, int r2, int c2,
                                              logic signed [15:0] v);
      req_item_type it;
      it.mode = m;
      it.row_first = 4'(r1);
      it.col_first = 4'(c1);
      it.row_last = 4'(r2);
      it.col_last = 4'(c2);
      it.cell_value = v;
      return it;
   endfunction

   // random item: fill the grid first, then mostly good queries with rebuilds
   function automatic req_item_type next_item();
      req_item_type it;
      int r, s, fr, fc, r1, r2, c1, c2;
      bit all_set;
      all_set = 1;
      s = $urandom_range(255);
      for (int n = 0; n < 256 && all_set; n++) begin
         fr = ((s + n) % 256) / 16;
         fc = (s + n) % 16;
         if (fr < sb.rows && fc < sb.cols && !written[fr][fc]) all_set = 0;
      end
      it = req_item_type'(ItemBits'({$urandom, $urandom}));
      r = $urandom_range(99);
      if (!all_set && r < 85) return make_item(MODE_WRITE, fr, fc, 0, 0, it.cell_value);
      if (all_set && !sb.built && r < 40) return make_item(MODE_BUILD, 0, 0, 0, 0, '0);
      if (r < 3) begin
         it.mode = MODE_WRITE;
         return it;
      end
      if (r < 8) begin
         // noise: bad ranges, unused mode, stray writes
         it.mode = (r == 3) ? MODE_UNUSED : ((r == 4) ? MODE_WRITE : MODE_QUERY);
         return it;
      end
      r1 = $urandom_range(sb.rows - 1);
      r2 = $urandom_range(sb.rows - 1);
      c1 = $urandom_range(sb.cols - 1);
      c2 = $urandom_range(sb.cols - 1);
      if (r1 > r2) begin r = r1; r1 = r2; r2 = r; end
      if (c1 > c2) begin r = c1; c1 = c2; c2 = r; end
      return make_item(MODE_QUERY, r1, c1, r2, c2, it.cell_value);
   endfunction

   // main sequence
   initial begin
      logic [CsrDataWidth-1:0] rows_cfg[NumPhases] = '{16, 16, 0, 31, 1, 5, 3, 16};
      logic [CsrDataWidth-1:0] cols_cfg[NumPhases] = '{16, 16, 0, 1, 31, 11, 7, 16};
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_OP_SELECT;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      calm = 0;
      builds_sent = 0;
      queries_sent = 0;
      foreach (written[i, j]) written[i][j] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < NumPhases; p++) begin
         calm = (p % 3 == 1);
         csr_write(CSR_OP_SELECT, CsrDataWidth'(p % 2));
         csr_write(CSR_GRID_ROWS, rows_cfg[p]);
         csr_write(CSR_GRID_COLS, cols_cfg[p]);
         @(posedge clock);
         if (p == 0) begin
            // extremes, queries before build, reversed ranges, unused mode
            send_item(make_item(MODE_WRITE, 0, 0, 0, 0, 16'sh8000));
            send_item(make_item(MODE_WRITE, 15, 15, 0, 0, 16'sh7fff));
            send_item(make_item(MODE_WRITE, 0, 15, 0, 0, 16'sh0000));
            send_item(make_item(MODE_WRITE, 15, 0, 0, 0, -16'sd1));
            send_item(make_item(MODE_QUERY, 0, 0, 15, 15, '0));
            send_item(make_item(MODE_QUERY, 5, 0, 4, 15, '0));
            send_item(make_item(MODE_QUERY, 0, 9, 15, 8, '0));
            send_item(make_item(MODE_UNUSED, 15, 15, 15, 15, 16'sh7fff));
         end
         if (p == 5) begin
            // writes and queries past the edges of a small grid, then a build and edge queries
            send_item(make_item(MODE_WRITE, 5, 0, 0, 0, 16'sd7));
            send_item(make_item(MODE_WRITE, 0, 11, 0, 0, 16'sd7));
            send_item(make_item(MODE_QUERY, 0, 0, 5, 10, '0));
            send_item(make_item(MODE_QUERY, 0, 0, 4, 11, '0));
            send_item(make_item(MODE_BUILD, 0, 0, 0, 0, '0));
            send_item(make_item(MODE_QUERY, 0, 0, 4, 10, '0));
            send_item(make_item(MODE_QUERY, 4, 10, 4, 10, '0));
         end
         for (int n = 0; n < ItemsPerPhase; n++) send_item(next_item());
         drain();
      end
      $display("covered %0d results over %0d grid settings, %0d builds and %0d queries",
               results_seen, NumPhases, builds_sent, queries_sent);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results still expected", sb.mismatches,
                  sb.pending.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // timeout
   initial begin
      #200ms;
      $display("timeout with %0d results still expected", sb.pending.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
